// ===== hw/rtl/pmba_pkg.sv =====
package pmba_pkg;

    localparam int NUM_WIDTH_REGS = 4;
    localparam int WIDTH_W        = 6;
    localparam int COUNT_W        = 14;
    localparam int ENTRY_W        = 13;
    localparam int FIELD_IDX_W    = 2;
    localparam int VALUE_W        = 32;
    localparam int REC_W          = 8;   // width of a record's bit count, at most four fields of 32 bits
    localparam int PROD_W         = ENTRY_W + REC_W;
    localparam int START_W        = PROD_W + 1;
    localparam int ACC_W          = VALUE_W + 8;  // up to five bytes gathered
    localparam int PADDR_W        = 5;
    localparam int REG_IDX_W      = PADDR_W - 2;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd8;
    localparam logic [31:0]        BYTE_MASK   = 32'h0000_00FF;

    localparam logic [REG_IDX_W-1:0] REG_WIDTH_0     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_1     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_2     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_3     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd4;

    typedef struct packed {
        logic [NUM_WIDTH_REGS-1:0][WIDTH_W-1:0] width;
        logic [COUNT_W-1:0]                     entry_count;
    } cfg_t;

    // Zero or oversized widths act as the maximum field width.
    function automatic logic [WIDTH_W-1:0] eff_width(logic [WIDTH_W-1:0] w,
                                                     logic [WIDTH_W-1:0] max_w);
        logic [WIDTH_W-1:0] r;
        r = w;
        if (w == '0 || w > max_w)
        begin
            r = max_w;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pmba_ram.sv =====
module pmba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/pmba_regs.sv =====
module pmba_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmba_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pmba_pkg::cfg_t                cfg
);

    pmba_pkg::cfg_t                    cfg_reg;
    logic                              wr_en;
    logic [pmba_pkg::REG_IDX_W-1:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[pmba_pkg::PADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pmba_pkg::NUM_WIDTH_REGS; i++)
            begin
                cfg_reg.width[i] <= pmba_pkg::WIDTH_RESET;
            end
            cfg_reg.entry_count <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                pmba_pkg::REG_WIDTH_0:     cfg_reg.width[0] <= pwdata[pmba_pkg::WIDTH_W-1:0];
                pmba_pkg::REG_WIDTH_1:     cfg_reg.width[1] <= pwdata[pmba_pkg::WIDTH_W-1:0];
                pmba_pkg::REG_WIDTH_2:     cfg_reg.width[2] <= pwdata[pmba_pkg::WIDTH_W-1:0];
                pmba_pkg::REG_WIDTH_3:     cfg_reg.width[3] <= pwdata[pmba_pkg::WIDTH_W-1:0];
                pmba_pkg::REG_ENTRY_COUNT:
                    cfg_reg.entry_count <= pwdata[pmba_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            pmba_pkg::REG_WIDTH_0:     prdata = 32'(cfg_reg.width[0]);
            pmba_pkg::REG_WIDTH_1:     prdata = 32'(cfg_reg.width[1]);
            pmba_pkg::REG_WIDTH_2:     prdata = 32'(cfg_reg.width[2]);
            pmba_pkg::REG_WIDTH_3:     prdata = 32'(cfg_reg.width[3]);
            pmba_pkg::REG_ENTRY_COUNT: prdata = 32'(cfg_reg.entry_count);
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/packed_multifield_bit_array_core.sv =====
// Packed record store: records of up to four fields (widths 1 to 32 bits, set
// through the register port) lie back to back in a byte-wide RAM of MEM_BYTES
// bytes. Each word on the input channel reads or writes one field; each gives
// one result word. The RAM is visited once per touched byte, read and then
// (for a write) merged and written back. An access steps through S_MUL and
// S_CHK, then S_RD and S_USE for each of the 1 to 5 bytes that the field
// spans, and ends in S_FIN; a rejected access goes from S_CHK to S_FIN. The
// input is stalled for the whole access. After reset a clearing pass zeroes
// the RAM, one byte a cycle, during which no input word is taken; registers
// may be written at any time the block is idle.
module packed_multifield_bit_array_core #(
    parameter int MEM_BYTES      = 4096,
    parameter int NUM_FIELDS     = 4,
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pmba_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [pmba_pkg::ENTRY_W-1:0]      entry_index,
    input  logic [pmba_pkg::FIELD_IDX_W-1:0]  field_index,
    input  logic [pmba_pkg::VALUE_W-1:0]      write_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pmba_pkg::VALUE_W-1:0]      result_value,
    output logic                              out_of_range
);

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int LIM_W  = $clog2(MEM_BYTES * 8) + 1;
    localparam int CMP_W  = (LIM_W > pmba_pkg::START_W) ? LIM_W : pmba_pkg::START_W;
    localparam int NF     = (NUM_FIELDS < pmba_pkg::NUM_WIDTH_REGS) ?
                            NUM_FIELDS : pmba_pkg::NUM_WIDTH_REGS;
    localparam logic [LIM_W-1:0]  LIMIT_BITS = LIM_W'(MEM_BYTES * 8);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(MEM_BYTES - 1);
    localparam logic [pmba_pkg::WIDTH_W-1:0] MAX_W = pmba_pkg::WIDTH_W'(MAX_FIELD_BITS);
    localparam logic [2:0] NF_CODE = 3'(NF);
    localparam int BASE_W = pmba_pkg::START_W - 3;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_USE  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    pmba_pkg::cfg_t cfg;

    pmba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [2:0]                         state_reg, state_next;
    logic [ADDR_W-1:0]                  clr_reg, clr_next;
    logic                               action_reg;
    logic [pmba_pkg::ENTRY_W-1:0]       entry_reg;
    logic [pmba_pkg::FIELD_IDX_W-1:0]   field_reg;
    logic [pmba_pkg::VALUE_W-1:0]       value_reg;
    logic [pmba_pkg::WIDTH_W-1:0]       w_reg, w_next;
    logic                               bad_reg, bad_next;
    logic [pmba_pkg::START_W-1:0]       start_reg, start_next;
    logic [BASE_W-1:0]                  base_reg, base_next;
    logic [2:0]                         bitoff_reg, bitoff_next;
    logic [2:0]                         last_reg, last_next;
    logic [2:0]                         k_reg, k_next;
    logic [pmba_pkg::ACC_W-1:0]         acc_reg, acc_next;
    logic                               out_valid_reg, out_valid_next;
    logic [pmba_pkg::VALUE_W-1:0]       result_reg, result_next;
    logic                               oor_reg, oor_next;

    logic [pmba_pkg::NUM_WIDTH_REGS-1:0][pmba_pkg::WIDTH_W-1:0] effw;
    logic [pmba_pkg::REC_W-1:0]         prefix, rec_bits;
    logic [pmba_pkg::PROD_W-1:0]        prod;
    logic [pmba_pkg::START_W-1:0]       end_bits;
    logic [6:0]                         span_top;
    logic [pmba_pkg::VALUE_W-1:0]       mask, vmask;
    logic [pmba_pkg::ACC_W-1:0]         vsh, msh;
    logic [7:0]                         vbyte, mbyte;

    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_waddr, ram_raddr, byte_addr;
    logic [7:0]                         ram_wdata, ram_rdata;

    pmba_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign out_of_range = oor_reg;

    always_comb
    begin
        prefix   = '0;
        rec_bits = '0;
        for (int f = 0; f < pmba_pkg::NUM_WIDTH_REGS; f++)
        begin
            effw[f] = pmba_pkg::eff_width(cfg.width[f], MAX_W);
            if (f < NF)
            begin
                rec_bits = rec_bits + pmba_pkg::REC_W'(effw[f]);
                if (2'(f) < field_reg)
                begin
                    prefix = prefix + pmba_pkg::REC_W'(effw[f]);
                end
            end
        end
    end

    assign prod      = {{pmba_pkg::REC_W{1'b0}}, entry_reg} *
                       {{pmba_pkg::ENTRY_W{1'b0}}, rec_bits};
    assign end_bits  = start_reg + pmba_pkg::START_W'(w_reg);
    assign span_top  = 7'(start_reg[2:0]) + 7'(w_reg) - 7'd1;
    assign mask      = ~(32'hFFFF_FFFF << w_reg);
    assign vmask     = value_reg & mask;
    assign vsh       = pmba_pkg::ACC_W'(vmask) << bitoff_reg;
    assign msh       = pmba_pkg::ACC_W'(mask) << bitoff_reg;
    assign vbyte     = 8'(vsh >> {k_reg, 3'b000});
    assign mbyte     = 8'(msh >> {k_reg, 3'b000});
    assign byte_addr = ADDR_W'({1'b0, base_reg} + (BASE_W + 1)'(k_reg));

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        w_next         = w_reg;
        bad_next       = bad_reg;
        start_next     = start_reg;
        base_next      = base_reg;
        bitoff_next    = bitoff_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;
        oor_next       = oor_reg;
        ram_we         = 1'b0;
        ram_waddr      = byte_addr;
        ram_wdata      = (ram_rdata & ~mbyte) | (vbyte & mbyte);
        ram_raddr      = byte_addr;

        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                w_next     = effw[field_reg];
                bad_next   = ({1'b0, field_reg} >= NF_CODE) ||
                             ({1'b0, entry_reg} >= cfg.entry_count);
                start_next = {1'b0, prod} + pmba_pkg::START_W'(prefix);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (CMP_W'(end_bits) > CMP_W'(LIMIT_BITS))
                begin
                    bad_next = 1'b1;
                end
                base_next   = start_reg[pmba_pkg::START_W-1:3];
                bitoff_next = start_reg[2:0];
                last_next   = span_top[5:3];
                k_next      = '0;
                acc_next    = '0;
                if (bad_reg || (CMP_W'(end_bits) > CMP_W'(LIMIT_BITS)))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_USE;
            end
            S_USE:
            begin
                // gather the byte; on a write merge the field bits back in
                acc_next = acc_reg | (pmba_pkg::ACC_W'(ram_rdata) << {k_reg, 3'b000});
                ram_we   = action_reg;
                if (k_reg == last_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    oor_next       = bad_reg;
                    if (bad_reg)
                    begin
                        result_next = action_reg ? ~value_reg : '0;
                    end
                    else if (action_reg)
                    begin
                        result_next = vmask;
                    end
                    else
                    begin
                        result_next = pmba_pkg::VALUE_W'(acc_reg >> bitoff_reg) & mask;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            action_reg <= action;
            entry_reg  <= entry_index;
            field_reg  <= field_index;
            value_reg  <= write_value;
        end
        w_reg      <= w_next;
        bad_reg    <= bad_next;
        start_reg  <= start_next;
        base_reg   <= base_next;
        bitoff_reg <= bitoff_next;
        last_reg   <= last_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        oor_reg    <= oor_next;
    end

    a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLR) || (state_reg == S_USE && action_reg))
        else $error("RAM written outside clear pass or field write");

    a_no_access_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_USE) |-> !bad_reg)
        else $error("rejected access reached the RAM");

    a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_USE) |-> (k_reg <= last_reg) && (last_reg <= 3'd4))
        else $error("byte index past field span");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside final step");

endmodule

// ===== tb/testbench.sv =====
module testbench;

    localparam int MEM_BYTES      = 4096;
    localparam int NUM_FIELDS     = 4;
    localparam int MAX_FIELD_BITS = 32;
    localparam int STORE_BITS     = MEM_BYTES * 8;
    localparam int RANDOM_ITEMS   = 440;
    localparam int WINDOW_ENTRIES = 16;
    localparam int LONG_HOLD      = 400;
    localparam logic ACT_READ     = 1'b0;
    localparam logic ACT_WRITE    = 1'b1;

    typedef struct {
        logic [pmba_pkg::VALUE_W-1:0] value;
        logic                         flagged;
    } field_result_t;

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             psel         = 1'b0;
    logic                             penable      = 1'b0;
    logic                             pwrite       = 1'b0;
    logic [pmba_pkg::PADDR_W-1:0]     paddr        = '0;
    logic [31:0]                      pwdata       = '0;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             in_valid     = 1'b0;
    logic                             in_stall;
    logic                             action       = ACT_READ;
    logic [pmba_pkg::ENTRY_W-1:0]     entry_index  = '0;
    logic [pmba_pkg::FIELD_IDX_W-1:0] field_index  = '0;
    logic [pmba_pkg::VALUE_W-1:0]     write_value  = '0;
    logic                             out_valid;
    logic                             out_stall    = 1'b0;
    logic [pmba_pkg::VALUE_W-1:0]     result_value;
    logic                             out_of_range;

    // Shadow of the block: byte store and register file
    logic [7:0]                   store_bytes [MEM_BYTES];
    logic [pmba_pkg::WIDTH_W-1:0] width_shadow [pmba_pkg::NUM_WIDTH_REGS];
    logic [pmba_pkg::COUNT_W-1:0] count_shadow;

    field_result_t pending_results [$];
    int  error_count    = 0;
    int  checked_count  = 0;
    int  read_count     = 0;
    int  write_count    = 0;
    int  rejected_count = 0;
    bit  gaps_on        = 1'b1;
    bit  stalls_on      = 1'b1;
    int  hold_cycles    = 0;

    packed_multifield_bit_array_core #(
        .MEM_BYTES      (MEM_BYTES),
        .NUM_FIELDS     (NUM_FIELDS),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .entry_index  (entry_index),
        .field_index  (field_index),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .out_of_range (out_of_range)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Zero or oversized widths behave as the widest field
    function automatic int unsigned field_bits(int unsigned f);
        logic [pmba_pkg::WIDTH_W-1:0] w;
        w = width_shadow[f];
        if (w == '0 || w > MAX_FIELD_BITS)
        begin
            return MAX_FIELD_BITS;
        end
        return 32'(w);
    endfunction

    function automatic int unsigned record_bits();
        int unsigned total;
        total = 0;
        for (int f = 0; f < NUM_FIELDS; f++)
        begin
            total += field_bits(f);
        end
        return total;
    endfunction

    function automatic field_result_t predict_field_access(
        logic                             act,
        logic [pmba_pkg::ENTRY_W-1:0]     entry,
        logic [pmba_pkg::FIELD_IDX_W-1:0] field,
        logic [pmba_pkg::VALUE_W-1:0]     value);
        field_result_t r;
        int unsigned   w;
        int unsigned   start_bit;
        int unsigned   bit_addr;
        logic [31:0]   masked;
        bit            bad;
        bad = (field >= NUM_FIELDS) || (entry >= count_shadow);
        w = field_bits(field);
        start_bit = 32'(entry);
        start_bit = start_bit * record_bits();
        for (int f = 0; f < field; f++)
        begin
            start_bit += field_bits(f);
        end
        if (start_bit + w > STORE_BITS)
        begin
            bad = 1'b1;
        end
        if (bad)
        begin
            r.value   = (act == ACT_WRITE) ? ~value : '0;
            r.flagged = 1'b1;
            return r;
        end
        masked = (w >= 32) ? value : (value & ((32'd1 << w) - 32'd1));
        r.value   = '0;
        r.flagged = 1'b0;
        for (int unsigned i = 0; i < w; i++)
        begin
            bit_addr = start_bit + i;
            if (act == ACT_WRITE)
            begin
                store_bytes[bit_addr >> 3][bit_addr & 7] = masked[i];
            end
            else
            begin
                r.value[i] = store_bytes[bit_addr >> 3][bit_addr & 7];
            end
        end
        if (act == ACT_WRITE)
        begin
            r.value = masked;
        end
        return r;
    endfunction

    // Offer one word and predict its result once it is taken
    task automatic send_word(logic act, int unsigned entry, int unsigned field,
                             logic [pmba_pkg::VALUE_W-1:0] value);
        int                               gap;
        field_result_t                    exp_res;
        logic [pmba_pkg::ENTRY_W-1:0]     entry_bits;
        logic [pmba_pkg::FIELD_IDX_W-1:0] field_bits_sel;
        entry_bits     = pmba_pkg::ENTRY_W'(entry);
        field_bits_sel = pmba_pkg::FIELD_IDX_W'(field);
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        entry_index <= entry_bits;
        field_index <= field_bits_sel;
        write_value <= value;
        do @(posedge clk); while (in_stall !== 1'b0);
        exp_res = predict_field_access(act, entry_bits, field_bits_sel, value);
        pending_results.insert(pending_results.size(), exp_res);
        if (act == ACT_WRITE)
        begin
            write_count++;
        end
        else
        begin
            read_count++;
        end
        if (exp_res.flagged)
        begin
            rejected_count++;
        end
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(logic [pmba_pkg::REG_IDX_W-1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < pmba_pkg::NUM_WIDTH_REGS)
        begin
            width_shadow[idx] = data[pmba_pkg::WIDTH_W-1:0];
        end
        else if (idx == pmba_pkg::REG_ENTRY_COUNT)
        begin
            count_shadow = data[pmba_pkg::COUNT_W-1:0];
        end
        @(posedge clk);
    endtask

    task automatic configure(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                             logic [31:0] w3, logic [31:0] count);
        settle_block();
        reg_write(pmba_pkg::REG_WIDTH_0, w0);
        reg_write(pmba_pkg::REG_WIDTH_1, w1);
        reg_write(pmba_pkg::REG_WIDTH_2, w2);
        reg_write(pmba_pkg::REG_WIDTH_3, w3);
        reg_write(pmba_pkg::REG_ENTRY_COUNT, count);
    endtask

    task automatic reset_block();
        for (int i = 0; i < MEM_BYTES; i++)
        begin
            store_bytes[i] = 8'h00;
        end
        for (int i = 0; i < pmba_pkg::NUM_WIDTH_REGS; i++)
        begin
            width_shadow[i] = pmba_pkg::WIDTH_RESET;
        end
        count_shadow = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // No record is valid right after reset
    task automatic test_unpopulated_store();
        send_word(ACT_READ, 0, 0, 32'h0);
        send_word(ACT_WRITE, 0, 1, 32'h1234_5678);
    endtask

    task automatic test_default_widths();
        configure(8, 8, 8, 8, 16);
        send_word(ACT_WRITE, 0, 0, 32'h0000_01A5);
        send_word(ACT_READ, 0, 0, 32'hFFFF_FFFF);
        send_word(ACT_READ, 1, 3, 32'h0);
        send_word(ACT_WRITE, 3, 2, 32'hFFFF_FFFF);
        send_word(ACT_READ, 3, 2, 32'h0);
        send_word(ACT_READ, 16, 0, 32'h0);
    endtask

    // Widths of 1 and 32, plus zero, 63 and 33 which act as 32
    task automatic test_width_extremes();
        configure(1, 32, 0, 63, 100);
        send_word(ACT_WRITE, 5, 0, 32'hFFFF_FFFF);
        send_word(ACT_WRITE, 5, 1, 32'hFFFF_FFFF);
        send_word(ACT_WRITE, 5, 2, 32'hDEAD_BEEF);
        send_word(ACT_WRITE, 4, 3, 32'hFFFF_FFFF);
        send_word(ACT_READ, 5, 0, 32'h0);
        send_word(ACT_READ, 5, 1, 32'h0);
        send_word(ACT_READ, 5, 2, 32'h0);
        send_word(ACT_READ, 5, 3, 32'h0);
        configure(33, 1, 1, 1, 100);
        send_word(ACT_READ, 2, 0, 32'h0);
        send_word(ACT_WRITE, 2, 3, 32'h0000_0000);
    endtask

    // Last bit of the store, spans past the end, unknown registers
    task automatic test_store_end();
        configure(32, 32, 32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_WRITE, 255, 3, 32'h8000_0001);
        send_word(ACT_READ, 255, 3, 32'h0);
        send_word(ACT_READ, 256, 0, 32'h0);
        send_word(ACT_WRITE, 8191, 3, 32'h5555_AAAA);
        configure(1, 1, 1, 1, 8192);
        send_word(ACT_WRITE, 8191, 3, 32'h0000_0001);
        send_word(ACT_READ, 8191, 3, 32'h0);
        settle_block();
        reg_write(pmba_pkg::REG_ENTRY_COUNT, 8191);
        for (int idx = pmba_pkg::REG_ENTRY_COUNT + 1; idx < (1 << pmba_pkg::REG_IDX_W); idx++)
        begin
            reg_write(pmba_pkg::REG_IDX_W'(idx), 32'hFFFF_FFFF);
        end
        send_word(ACT_READ, 8191, 3, 32'h0);
        send_word(ACT_READ, 8190, 2, 32'h0);
    endtask

    function automatic logic [31:0] draw_width();
        case ($urandom_range(0, 6))
            0: return 1;
            1: return 32;
            2: return ($urandom_range(0, 1) != 0) ? 63 : 0;
            default: return $urandom_range(1, 32);
        endcase
    endfunction

    task automatic test_random_traffic();
        int          sent;
        int          phase_len;
        int unsigned cap;
        int unsigned limit;
        int unsigned base;
        int unsigned span;
        int unsigned entry;
        logic [31:0] count;
        logic [31:0] value;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle_block();
            for (int idx = pmba_pkg::REG_WIDTH_0; idx <= pmba_pkg::REG_WIDTH_3; idx++)
            begin
                reg_write(pmba_pkg::REG_IDX_W'(idx), ($urandom() & ~32'h3F) | draw_width());
            end
            cap = STORE_BITS / record_bits();
            case ($urandom_range(0, 3))
                0: count = 32'h3FFF;
                1: count = cap;
                2: count = $urandom_range(1, cap);
                default: count = $urandom_range(1, 8192);
            endcase
            reg_write(pmba_pkg::REG_ENTRY_COUNT, ($urandom() & ~32'h3FFF) | count);
            limit = (count < cap) ? count : cap;
            span  = (limit < WINDOW_ENTRIES) ? limit : WINDOW_ENTRIES;
            base  = $urandom_range(0, limit - span);
            case ($urandom_range(0, 3))
                0:
                begin
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                end
                1:
                begin
                    gaps_on   = 1'b1;
                    stalls_on = 1'b0;
                end
                default:
                begin
                    gaps_on   = 1'b1;
                    stalls_on = 1'b1;
                end
            endcase
            phase_len = $urandom_range(50, 110);
            if (phase_len > RANDOM_ITEMS - sent)
            begin
                phase_len = RANDOM_ITEMS - sent;
            end
            for (int n = 0; n < phase_len; n++)
            begin
                // Keep most traffic inside a small window so reads hit written data
                if ($urandom_range(0, 99) < 85)
                begin
                    entry = base + $urandom_range(0, span - 1);
                end
                else
                begin
                    entry = $urandom_range(0, (1 << pmba_pkg::ENTRY_W) - 1);
                end
                case ($urandom_range(0, 9))
                    0: value = 32'h0;
                    1: value = 32'hFFFF_FFFF;
                    default: value = $urandom();
                endcase
                send_word($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, entry,
                          $urandom_range(0, 3), value);
            end
            sent += phase_len;
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Hold the output long enough for the block to back up into its input
    task automatic test_output_backpressure();
        configure(8, 8, 8, 8, 1024);
        gaps_on     = 1'b0;
        hold_cycles = LONG_HOLD;
        for (int n = 0; n < 40; n++)
        begin
            send_word($urandom_range(0, 1) ? ACT_WRITE : ACT_READ,
                      $urandom_range(0, 31), $urandom_range(0, 3), $urandom());
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        reset_block();
        test_unpopulated_store();
        test_default_widths();
        test_width_extremes();
        test_store_end();
        test_random_traffic();
        test_output_backpressure();
        settle_block();
        repeat (20) @(posedge clk);
        $display("Checked %0d result words: %0d reads, %0d writes, %0d rejected accesses",
                 checked_count, read_count, write_count, rejected_count);
        $display("Covered width extremes, store end, unknown registers and output backpressure");
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Receiver: random hold-off after each word, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                stall_left = stalls_on ? $urandom_range(0, 7) : 0;
            end
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        field_result_t exp_res;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: result_value %h out_of_range %b",
                       result_value, out_of_range);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                checked_count++;
                if (result_value !== exp_res.value)
                begin
                    $error("result_value: expected %h, got %h", exp_res.value, result_value);
                    error_count++;
                end
                if (out_of_range !== exp_res.flagged)
                begin
                    $error("out_of_range: expected %b, got %b", exp_res.flagged, out_of_range);
                    error_count++;
                end
            end
        end
    end

endmodule

// ===== packed_multifield_bit_array_core.f =====
hw/rtl/pmba_pkg.sv
hw/rtl/pmba_ram.sv
hw/rtl/pmba_regs.sv
hw/rtl/packed_multifield_bit_array_core.sv
tb/testbench.sv
